FILE: rtl/core/pcdr_pkg.sv
// Shared widths and constants for the dice range prime counter.
package pcdr_pkg;

  // Width of the value path; the range end saturates at its largest value.
  localparam int VALUE_BITS = 12;

  // Field widths of the input and result words.
  localparam int FACES_BITS = 8;
  localparam int DICE_BITS  = 5;
  localparam int COUNT_BITS = 12;

  // Full width of the range end product before saturation.
  localparam int PROD_BITS = FACES_BITS + DICE_BITS;

  // Width that holds the raw product, the dice count and the saturation limit.
  localparam int WIDE_BITS = (VALUE_BITS > PROD_BITS) ? VALUE_BITS : PROD_BITS;

  // Index of one bit of a value, used by the bit-serial remainder unit.
  localparam int BIT_IDX_BITS = $clog2(VALUE_BITS);

  // Smallest divisor tried.
  localparam int FIRST_DIVISOR = 2;

endpackage

FILE: rtl/core/prime_count_in_dice_range.sv
// Top level of the dice range prime counter with a shared bit-serial remainder unit.
//
//   channel   direction  handshake              word
//   command   in         start, busy            die_faces, dice_count
//   result    out        done (one-cycle pulse) prime_total
//
// A command word is taken at a clock edge with start high and busy low. The block
// then walks every value from dice_count to min(die_faces * dice_count, 2^VALUE_BITS - 1)
// and trial-divides it. Each value passes through a value step and a next step, plus a
// check step and a remainder pass for every divisor tried, plus a final square check for
// a value that survives. The restoring remainder unit retires one value bit per cycle.
// Reset is synchronous and clears the sequencer and the done pulse. The result
// shows for one cycle on done; the receiver cannot stall it.
module prime_count_in_dice_range (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pcdr_pkg::FACES_BITS-1:0] die_faces,
  input  logic [pcdr_pkg::DICE_BITS-1:0]  dice_count,
  output logic                            done,
  output logic [pcdr_pkg::COUNT_BITS-1:0] prime_total
);
  import pcdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_VALUE,
    ST_CHECK,
    ST_DIV,
    ST_NEXT
  } state_t;

  state_t                  state;
  logic                    empty;
  logic [VALUE_BITS-1:0]   v;
  logic [VALUE_BITS-1:0]   last;
  logic [VALUE_BITS-1:0]   d;
  logic [VALUE_BITS:0]     dsq;
  logic [VALUE_BITS-1:0]   r;
  logic [BIT_IDX_BITS-1:0] bit_idx;
  logic [COUNT_BITS-1:0]   count;

  logic                    accept;
  logic [PROD_BITS-1:0]    prod;
  logic [WIDE_BITS-1:0]    last_wide;
  logic [WIDE_BITS-1:0]    last_sat;
  logic [WIDE_BITS-1:0]    dice_wide;
  logic [WIDE_BITS-1:0]    vmax_wide;
  logic [VALUE_BITS:0]     r_shift;
  logic [VALUE_BITS:0]     r_sub;
  logic [VALUE_BITS-1:0]   r_next;
  logic [VALUE_BITS:0]     dsq_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Range end: product of the fields, saturated to the value path.
  assign prod      = PROD_BITS'(die_faces) * PROD_BITS'(dice_count);
  assign last_wide = WIDE_BITS'(prod);
  assign vmax_wide = WIDE_BITS'({VALUE_BITS{1'b1}});
  assign last_sat  = (last_wide > vmax_wide) ? vmax_wide : last_wide;
  assign dice_wide = WIDE_BITS'(dice_count);

  // Restoring remainder step: bring in one bit of the value, subtract when it fits.
  assign r_shift = {r, v[bit_idx]};
  assign r_sub   = r_shift - {1'b0, d};
  assign r_next  = (r_shift >= {1'b0, d}) ? r_sub[VALUE_BITS-1:0] : r_shift[VALUE_BITS-1:0];

  // Square of the next divisor: (d + 1)^2 = d^2 + 2d + 1.
  assign dsq_next = dsq + {d, 1'b0} + (VALUE_BITS+1)'(1);

  // Sequencer over the values of the range and the divisors of each value.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (accept) begin
            empty <= (dice_wide > last_sat);
            v     <= dice_wide[VALUE_BITS-1:0];
            last  <= last_sat[VALUE_BITS-1:0];
            count <= '0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (empty) begin
            done        <= 1'b1;
            prime_total <= count;
            state       <= ST_IDLE;
          end else begin
            done  <= 1'b0;
            state <= ST_VALUE;
          end
        end
        ST_VALUE: begin
          // Values below two are never prime.
          if (v < VALUE_BITS'(FIRST_DIVISOR)) begin
            state <= ST_NEXT;
          end else begin
            d     <= VALUE_BITS'(FIRST_DIVISOR);
            dsq   <= (VALUE_BITS+1)'(FIRST_DIVISOR * FIRST_DIVISOR);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // No divisor up to the square root: the value is prime.
          if (dsq > {1'b0, v}) begin
            count <= count + COUNT_BITS'(1);
            state <= ST_NEXT;
          end else begin
            r       <= '0;
            bit_idx <= BIT_IDX_BITS'(VALUE_BITS - 1);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          r <= r_next;
          if (bit_idx == '0) begin
            if (r_next == '0) begin
              state <= ST_NEXT;
            end else begin
              d     <= d + VALUE_BITS'(1);
              dsq   <= dsq_next;
              state <= ST_CHECK;
            end
          end else begin
            bit_idx <= bit_idx - BIT_IDX_BITS'(1);
          end
        end
        ST_NEXT: begin
          if (v == last) begin
            done        <= 1'b1;
            prime_total <= count;
            state       <= ST_IDLE;
          end else begin
            done  <= 1'b0;
            v     <= v + VALUE_BITS'(1);
            state <= ST_VALUE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted word always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  // A result pulse lasts one cycle and leaves the block ready.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result pulse too long or block still busy");

  // The remainder unit never divides by zero or one.
  a_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (d >= VALUE_BITS'(FIRST_DIVISOR)))
    else $error("trial divisor below two");
`endif

endmodule
